FILE: rtl/cdg_graphics_packet_renderer_macros.svh
// ----------------------------------------------------------------------------
// cdg renderer assertion macros
// include-guarded helpers for concurrent assertions
// ----------------------------------------------------------------------------
`ifndef CDG_GRAPHICS_PACKET_RENDERER_MACROS_SVH
`define CDG_GRAPHICS_PACKET_RENDERER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CDG_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define CDG_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define CDG_ASSERT_IMP(label, clk, rst_n, a, c)
`define CDG_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: rtl/cdg_pkg.sv
// ----------------------------------------------------------------------------
// cdg package
// shared types and constants of the cd+g packet renderer
// ----------------------------------------------------------------------------
package cdg_pkg;
    localparam int SCREEN_WIDTH  = 300;
    localparam int SCREEN_HEIGHT = 216;
    localparam int TILE_WIDTH    = 6;
    localparam int TILE_HEIGHT   = 12;
    localparam int WORDS_PER_ROW = SCREEN_WIDTH / TILE_WIDTH;
    localparam int FS_DEPTH      = WORDS_PER_ROW * SCREEN_HEIGHT;
    localparam int FS_AW         = $clog2(FS_DEPTH);

    localparam logic [5:0] GRAPHICS_MODE   = 6'd9;
    localparam logic [5:0] INS_PRESET      = 6'd1;
    localparam logic [5:0] INS_COLORS_LOW  = 6'd30;
    localparam logic [5:0] INS_COLORS_HIGH = 6'd31;
    localparam logic [5:0] INS_TILE        = 6'd6;
    localparam logic [5:0] INS_TILE_XOR    = 6'd38;

    localparam logic [2:0] ST_DONE        = 3'd0;
    localparam logic [2:0] ST_NOT_GFX     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN     = 3'd2;
    localparam logic [2:0] ST_TILE_OUT    = 3'd3;
    localparam logic [2:0] ST_READ_OUT    = 3'd4;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_FILL, S_TILE_RD, S_TILE_WR, S_PIX_RD, S_PIX_OUT, S_RESULT
    } state_t;

    // frame store access from the sequencer
    typedef struct packed {
        logic             rd;
        logic             wr;
        logic [FS_AW-1:0] addr;
        logic [23:0]      wdata;
    } fs_req_t;
endpackage

FILE: rtl/cdg_frame_ram.sv
// ----------------------------------------------------------------------------
// cdg frame store
// single-port synchronous ram of six-pixel words, registered read
// ----------------------------------------------------------------------------
module cdg_frame_ram (
    input  logic             clk,
    input  cdg_pkg::fs_req_t req,
    output logic [23:0]      rdata
);
    import cdg_pkg::*;

    logic [23:0] mem [FS_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata <= mem[req.addr];
        end
    end
endmodule

FILE: rtl/cdg_graphics_packet_renderer.sv
// ----------------------------------------------------------------------------
// cdg graphics packet renderer
// cd+g graphics packet decoder with frame store and palette
// ----------------------------------------------------------------------------
// One word in, one word out. After reset the frame store is cleared by a
// pass over all its words (one word of six pixels per cycle) before the
// first input word is taken. A pixel read reads its word, then registers
// the pixel; a colour load, an ignored packet, a preset with repeat set or
// a dropped tile go straight to the result; a tile draw reads then writes
// each of its twelve row words on the single frame store port; a screen
// preset fills the store, one store write per cycle. The result sits in an
// output register; the next input word is taken once it has gone.
module cdg_graphics_packet_renderer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, command, instruction, data_low, data_high, read_x, read_y: bits 0..125
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, pixel_index, red, green, blue: bits 0..30
    output logic [31:0]  m_tdata
);
    import cdg_pkg::*;
    `include "cdg_graphics_packet_renderer_macros.svh"

    state_t state_reg, state_next;
    logic [FS_AW-1:0] addr_reg, addr_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        out_valid_reg;
    logic [30:0] out_reg;
    logic [2:0]  status_reg, status_next;
    logic        xor_reg;
    logic [3:0]  c0_reg, c1_reg;
    logic [71:0] rows_reg;
    logic [3:0]  pal_r [16];
    logic [3:0]  pal_g [16];
    logic [3:0]  pal_b [16];
    logic [2:0]  sub_reg;
    logic [23:0] rdata;
    fs_req_t     req;

    logic        op;
    logic [5:0]  command, instruction;
    logic [47:0] dlo, dhi;
    logic [8:0]  rx;
    logic [7:0]  ry;
    logic [95:0] dall;
    logic        accept;

    assign op          = s_tdata[0];
    assign command     = s_tdata[6:1];
    assign instruction = s_tdata[12:7];
    assign dlo         = s_tdata[60:13];
    assign dhi         = s_tdata[108:61];
    assign rx          = s_tdata[117:109];
    assign ry          = s_tdata[125:118];
    assign dall        = {dhi, dlo};
    assign s_tready    = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept      = s_tvalid && s_tready;

    // tile position checks
    logic [5:0] t_col;
    logic [4:0] t_row;
    logic       tile_ok;
    logic [FS_AW-1:0] tile_addr;
    assign t_col     = dall[23:18];
    assign t_row     = dall[16:12];
    assign tile_ok   = (32'(t_col) < 32'(WORDS_PER_ROW))
                       && (32'(t_row) * 32'(TILE_HEIGHT) + 32'(TILE_HEIGHT)
                           <= 32'(SCREEN_HEIGHT));
    assign tile_addr = FS_AW'(32'(t_row) * 32'(TILE_HEIGHT * WORDS_PER_ROW)
                              + 32'(t_col));

    // pixel read address: word and sub position
    logic [8:0] rd_word;
    logic [2:0] rd_sub;
    logic       rd_ok;
    assign rd_ok   = (32'(rx) < 32'(SCREEN_WIDTH)) && (32'(ry) < 32'(SCREEN_HEIGHT));
    assign rd_word = 9'((32'(rx) * 32'd43691) >> 18);
    assign rd_sub  = 3'(32'(rx) - 32'(rd_word) * 32'(TILE_WIDTH));

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                addr_next = addr_reg + 1'b1;
                if (32'(addr_reg) == FS_DEPTH - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next = ST_DONE;
                    state_next  = S_RESULT;
                    if (op)
                    begin
                        if (rd_ok)
                        begin
                            addr_next  = FS_AW'(32'(ry) * 32'(WORDS_PER_ROW)
                                               + 32'(rd_word));
                            state_next = S_PIX_RD;
                        end
                        else
                        begin
                            status_next = ST_READ_OUT;
                        end
                    end
                    else if (command != GRAPHICS_MODE)
                    begin
                        status_next = ST_NOT_GFX;
                    end
                    else if (instruction == INS_PRESET)
                    begin
                        addr_next = '0;
                        if (dall[9:6] == 4'd0)
                        begin
                            state_next = S_FILL;
                        end
                    end
                    else if (instruction == INS_COLORS_LOW
                             || instruction == INS_COLORS_HIGH)
                    begin
                        state_next = S_RESULT;
                    end
                    else if (instruction == INS_TILE || instruction == INS_TILE_XOR)
                    begin
                        if (tile_ok)
                        begin
                            addr_next  = tile_addr;
                            cnt_next   = '0;
                            state_next = S_TILE_RD;
                        end
                        else
                        begin
                            status_next = ST_TILE_OUT;
                        end
                    end
                    else
                    begin
                        status_next = ST_UNKNOWN;
                    end
                end
            end
            S_FILL:
            begin
                addr_next = addr_reg + 1'b1;
                if (32'(addr_reg) == FS_DEPTH - 1)
                begin
                    state_next = S_RESULT;
                end
            end
            S_TILE_RD:
            begin
                state_next = S_TILE_WR;
            end
            S_TILE_WR:
            begin
                addr_next = FS_AW'(32'(addr_reg) + WORDS_PER_ROW);
                cnt_next  = cnt_reg + 1'b1;
                state_next = (cnt_reg == 4'(TILE_HEIGHT - 1)) ? S_RESULT : S_TILE_RD;
            end
            S_PIX_RD:
            begin
                state_next = S_PIX_OUT;
            end
            S_PIX_OUT:
            begin
                state_next = S_IDLE;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // tile row word: bit 5 of the row byte is the leftmost pixel, pixel 0 low
    logic [5:0]  row_bits;
    logic [23:0] tile_word;
    assign row_bits = rows_reg[6*cnt_reg +: 6];
    always_comb
    begin
        for (int p = 0; p < TILE_WIDTH; p++)
        begin
            tile_word[4*p +: 4] = (row_bits[5-p] ? c1_reg : c0_reg)
                                  ^ (xor_reg ? rdata[4*p +: 4] : 4'd0);
        end
    end

    always_comb
    begin
        req.rd    = 1'b0;
        req.wr    = 1'b0;
        req.addr  = addr_reg;
        req.wdata = '0;
        unique case (state_reg)
            S_CLEAR:   req.wr = 1'b1;
            S_FILL:
            begin
                req.wr    = 1'b1;
                req.wdata = {6{c0_reg}};
            end
            S_TILE_RD: req.rd = 1'b1;
            S_TILE_WR:
            begin
                req.wr    = 1'b1;
                req.wdata = tile_word;
            end
            S_PIX_RD:  req.rd = 1'b1;
            default:   req.rd = 1'b0;
        endcase
    end

    cdg_frame_ram u_ram (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    logic [3:0] pix;
    assign pix = rdata[4*sub_reg +: 4];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            c0_reg   <= dall[3:0];
            c1_reg   <= dall[9:6];
            xor_reg  <= (instruction == INS_TILE_XOR);
            rows_reg <= dall[95:24];
            sub_reg  <= rd_sub;
        end
        if (state_reg == S_PIX_OUT)
        begin
            out_reg <= {8'(pal_b[pix] * 8'd17), 8'(pal_g[pix] * 8'd17),
                        8'(pal_r[pix] * 8'd17), pix, ST_DONE};
        end
        else if (state_reg == S_RESULT)
        begin
            out_reg <= {28'd0, status_reg};
        end
    end

    // palette, black after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pal_r[i] <= '0;
                pal_g[i] <= '0;
                pal_b[i] <= '0;
            end
        end
        else if (accept && !op && command == GRAPHICS_MODE
                 && (instruction == INS_COLORS_LOW || instruction == INS_COLORS_HIGH))
        begin
            for (int i = 0; i < 8; i++)
            begin
                pal_r[{instruction[0], 3'(i)}] <= dall[12*i+2 +: 4];
                pal_g[{instruction[0], 3'(i)}] <= {dall[12*i +: 2], dall[12*i+10 +: 2]};
                pal_b[{instruction[0], 3'(i)}] <= dall[12*i+6 +: 4];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            cnt_reg       <= '0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            if (state_reg == S_PIX_OUT || state_reg == S_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

    `CDG_ASSERT_IMP(a_no_take_busy, clk, rst_n, out_valid_reg, !s_tready)
    `CDG_ASSERT_NXT(a_tile_row_pair, clk, rst_n, state_reg == S_TILE_RD, state_reg == S_TILE_WR)
    `CDG_ASSERT_NXT(a_pix_pair, clk, rst_n, state_reg == S_PIX_RD, state_reg == S_PIX_OUT)
    `CDG_ASSERT_IMP(a_tile_cnt, clk, rst_n, state_reg == S_TILE_WR, cnt_reg < 4'(TILE_HEIGHT))
endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cd+g packet renderer testbench
// drives graphics packets and pixel reads, predicts every result word from
// a local copy of the frame store and palette, and checks each field
// ----------------------------------------------------------------------------
module tb_top;
    import cdg_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct {
        logic        op;
        logic [5:0]  command;
        logic [5:0]  instruction;
        logic [47:0] data_low;
        logic [47:0] data_high;
        logic [8:0]  read_x;
        logic [7:0]  read_y;
    } packet_t;

    typedef struct {
        logic [2:0] status;
        logic [3:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;

    packet_t       pending_packets[$];
    pixel_result_t expected_pixels[$];
    packet_t       offered;
    logic [3:0]    screen[SCREEN_WIDTH*SCREEN_HEIGHT];
    logic [11:0]   colour_table[16];
    int            n_accepted;
    int            n_errors;
    int            quiet_cycles;
    int            hold_count;
    bit            hold_done;
    bit            s_took;

    cdg_graphics_packet_renderer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [127:0] pack_word(packet_t p);
        logic [125:0] w;
        w = {p.read_y, p.read_x, p.data_high, p.data_low, p.instruction, p.command, p.op};
        return {2'b00, w};
    endfunction

    function automatic logic [5:0] data_byte(packet_t p, int k);
        logic [47:0] src;
        src = (k < 8) ? p.data_low : p.data_high;
        return src[(k % 8)*6 +: 6];
    endfunction

    // update the shadow screen and palette and work out the result word
    function automatic pixel_result_t render(packet_t p);
        pixel_result_t res;
        logic [3:0]    c0, c1, c, v;
        logic [5:0]    a, b, bits;
        int            x0, y0;
        res = '{default: '0};
        if (p.op)
        begin
            if (p.read_x >= SCREEN_WIDTH || p.read_y >= SCREEN_HEIGHT)
                res.status = ST_READ_OUT;
            else
            begin
                v = screen[p.read_y * SCREEN_WIDTH + p.read_x];
                res.pixel_index = v;
                res.red   = colour_table[v][11:8] * 8'd17;
                res.green = colour_table[v][7:4] * 8'd17;
                res.blue  = colour_table[v][3:0] * 8'd17;
            end
            return res;
        end
        if (p.command != GRAPHICS_MODE)
            res.status = ST_NOT_GFX;
        else if (p.instruction == INS_PRESET)
        begin
            if ((data_byte(p, 1) & 6'h0F) == 6'h00)
                foreach (screen[i]) screen[i] = 4'(data_byte(p, 0) & 6'h0F);
        end
        else if (p.instruction == INS_COLORS_LOW || p.instruction == INS_COLORS_HIGH)
        begin
            for (int i = 0; i < 8; i++)
            begin
                a = data_byte(p, 2*i);
                b = data_byte(p, 2*i + 1);
                colour_table[(p.instruction == INS_COLORS_HIGH ? 8 : 0) + i] =
                    {a[5:2], a[1:0], b[5:4], b[3:0]};
            end
        end
        else if (p.instruction == INS_TILE || p.instruction == INS_TILE_XOR)
        begin
            c0 = 4'(data_byte(p, 0) & 6'h0F);
            c1 = 4'(data_byte(p, 1) & 6'h0F);
            y0 = (data_byte(p, 2) & 6'h1F) * TILE_HEIGHT;
            x0 = data_byte(p, 3) * TILE_WIDTH;
            if (x0 + TILE_WIDTH > SCREEN_WIDTH || y0 + TILE_HEIGHT > SCREEN_HEIGHT)
                res.status = ST_TILE_OUT;
            else
                for (int r = 0; r < TILE_HEIGHT; r++)
                begin
                    bits = data_byte(p, 4 + r);
                    for (int q = 0; q < TILE_WIDTH; q++)
                    begin
                        c = bits[5-q] ? c1 : c0;
                        if (p.instruction == INS_TILE_XOR)
                            c ^= screen[(y0 + r) * SCREEN_WIDTH + x0 + q];
                        screen[(y0 + r) * SCREEN_WIDTH + x0 + q] = c;
                    end
                end
        end
        else
            res.status = ST_UNKNOWN;
        return res;
    endfunction

    function automatic packet_t random_packet();
        packet_t p;
        int      pick;
        p.op          = 1'b0;
        p.command     = GRAPHICS_MODE;
        p.instruction = 6'($urandom);
        p.data_low    = 48'({$urandom, $urandom});
        p.data_high   = 48'({$urandom, $urandom});
        p.read_x      = 9'($urandom);
        p.read_y      = 8'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 350)
        begin
            p.op = 1'b1;
            p.command = 6'($urandom);
            if (pick < 320)
            begin
                p.read_x = 9'($urandom_range(0, SCREEN_WIDTH - 1));
                p.read_y = 8'($urandom_range(0, SCREEN_HEIGHT - 1));
            end
        end
        else if (pick < 680)
        begin
            p.instruction = pick[0] ? INS_TILE : INS_TILE_XOR;
            if (pick < 650)
            begin
                p.data_low[17:12] = {1'($urandom_range(0, 1)), 5'($urandom_range(0, 17))};
                p.data_low[23:18] = 6'($urandom_range(0, 49));
            end
        end
        else if (pick < 800)
            p.instruction = pick[0] ? INS_COLORS_LOW : INS_COLORS_HIGH;
        else if (pick < 810)
        begin
            p.instruction = INS_PRESET;
            // a real fill is slow, so only about half of the presets clear repeat
            if (pick[0])
                p.data_low[9:6] = 4'd0;
        end
        else if (pick < 900)
            p.command = 6'($urandom);
        // the rest keeps a random instruction
        return p;
    endfunction

    function automatic packet_t gfx(logic [5:0] ins, logic [47:0] lo, logic [47:0] hi);
        packet_t p;
        p = '{op: 1'b0, command: GRAPHICS_MODE, instruction: ins, data_low: lo,
              data_high: hi, read_x: 9'($urandom), read_y: 8'($urandom)};
        return p;
    endfunction

    function automatic packet_t rd(int x, int y);
        packet_t p;
        p = '{op: 1'b1, command: 6'($urandom), instruction: 6'($urandom),
              data_low: 48'({$urandom, $urandom}), data_high: 48'({$urandom, $urandom}),
              read_x: 9'(x), read_y: 8'(y)};
        return p;
    endfunction

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        packet_t p;
        pending_packets.push_back(rd(0, 0));
        pending_packets.push_back(rd(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1));
        pending_packets.push_back(rd(SCREEN_WIDTH, 0));
        pending_packets.push_back(rd(0, SCREEN_HEIGHT));
        pending_packets.push_back(rd(511, 255));
        pending_packets.push_back(gfx(INS_COLORS_LOW, '1, '1));
        pending_packets.push_back(gfx(INS_COLORS_HIGH, 48'h123456789ABC, 48'hFEDCBA987654));
        pending_packets.push_back(gfx(INS_TILE, {{8{6'h2A}}}, '1));
        pending_packets.push_back(rd(0, 0));
        pending_packets.push_back(gfx(INS_TILE, {36'hFFFFFFFFF, 6'd49, 6'd17}, '0));
        pending_packets.push_back(rd(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1));
        pending_packets.push_back(gfx(INS_TILE_XOR, {24'hABCDEF, 6'd0, 6'd0, 12'h3C5}, '1));
        pending_packets.push_back(rd(5, 11));
        pending_packets.push_back(gfx(INS_TILE, {24'h0, 6'd50, 6'd0, 12'h0}, '0));
        pending_packets.push_back(gfx(INS_TILE, {24'h0, 6'd0, 6'd18, 12'h0}, '0));
        pending_packets.push_back(gfx(INS_TILE_XOR, {24'h0, 6'd63, 6'd31, 12'h0}, '0));
        pending_packets.push_back(gfx(INS_PRESET, {36'h0, 6'h01, 6'h07}, '0));
        pending_packets.push_back(rd(100, 100));
        pending_packets.push_back(gfx(INS_PRESET, {36'h0, 6'h30, 6'h0D}, '0));
        pending_packets.push_back(rd(299, 0));
        pending_packets.push_back(gfx(6'd0, '0, '0));
        pending_packets.push_back(gfx(6'd63, '1, '1));
        pending_packets.push_back(gfx(6'd28, '0, '0));
        p = gfx(INS_PRESET, '0, '0);
        p.command = 6'd0;
        pending_packets.push_back(p);
        p.command = 6'd63;
        pending_packets.push_back(p);
        repeat (1450) pending_packets.push_back(random_packet());

        wait (pending_packets.size() == 0 && !s_tvalid);
        wait (expected_pixels.size() == 0);
        repeat (50) @(posedge clk);
        if (n_errors == 0 && expected_pixels.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else if (!s_tvalid || s_took)
        begin
            if (pending_packets.size() != 0 &&
                $urandom_range(0, 99) >= (n_accepted < 500 ? 15 : n_accepted < 1000 ? 85 : 0))
            begin
                offered  = pending_packets.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= pack_word(offered);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver, with one long hold-off while the sender keeps offering
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            hold_count <= 0;
            hold_done  <= 1'b0;
        end
        else if (!hold_done && n_accepted >= 300)
        begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES)
                hold_done <= 1'b1;
        end
        else
            m_tready <= $urandom_range(0, 99) >=
                        (n_accepted < 500 ? 85 : n_accepted < 1000 ? 15 : 0);
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        if (!rst_n)
        begin
            n_accepted   <= 0;
            n_errors     = 0;
            quiet_cycles <= 0;
            s_took       <= 1'b0;
            foreach (screen[i]) screen[i] = '0;
            foreach (colour_table[i]) colour_table[i] = '0;
        end
        else
        begin
            s_took <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result word with nothing expected: %h", m_tdata);
                    n_errors++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[2:0] !== want.status)
                    begin
                        $error("status expected %0d got %0d", want.status, m_tdata[2:0]);
                        n_errors++;
                    end
                    if (m_tdata[6:3] !== want.pixel_index)
                    begin
                        $error("pixel_index expected %0d got %0d", want.pixel_index,
                               m_tdata[6:3]);
                        n_errors++;
                    end
                    if (m_tdata[14:7] !== want.red)
                    begin
                        $error("red expected %0d got %0d", want.red, m_tdata[14:7]);
                        n_errors++;
                    end
                    if (m_tdata[22:15] !== want.green)
                    begin
                        $error("green expected %0d got %0d", want.green, m_tdata[22:15]);
                        n_errors++;
                    end
                    if (m_tdata[30:23] !== want.blue)
                    begin
                        $error("blue expected %0d got %0d", want.blue, m_tdata[30:23]);
                        n_errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_pixels.push_back(render(offered));
                n_accepted <= n_accepted + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
